// ----- hw/rtl/plts_pkg.sv -----
package plts_pkg;

    localparam int unsigned TEMP_W   = 12;
    localparam int unsigned UTIL_W   = 10;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SUST_W   = 20;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned FAIL_W   = 8;
    localparam int unsigned CALM_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [DELAY_W-1:0] BUSY_DELAY_MS = 16'd2000;
    localparam logic [DELAY_W-1:0] CALM_DELAY_MS = 16'd10000;
    localparam logic [FAIL_W-1:0]  FAIL_MAX      = 8'd255;
    localparam logic [CALM_W-1:0]  CALM_MAX      = 4'd15;

    localparam logic signed [TEMP_W-1:0] ALARM_SET_RST   = 12'sd850;
    localparam logic signed [TEMP_W-1:0] ALARM_CLEAR_RST = 12'sd830;
    localparam logic [SUST_W-1:0]        SUSTAIN_RST     = 20'd30000;
    localparam logic [UTIL_W-1:0]        BUSY_UTIL_RST   = 10'd150;
    localparam logic signed [TEMP_W-1:0] BUSY_TEMP_RST   = 12'sd750;
    localparam logic [FAIL_W-1:0]        FAILS_RST       = 8'd3;
    localparam logic [CALM_W-1:0]        RELAX_RST       = 4'd5;
    localparam logic [DELAY_W-1:0]       CAP_RST         = 16'd30000;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_NODRIVER = 2'd1,
        ST_ALARM    = 2'd2,
        ST_OFFLINE  = 2'd3
    } health_t;

    typedef enum logic [1:0] {
        CAD_NONE   = 2'd0,
        CAD_TO_BUSY = 2'd1,
        CAD_TO_CALM = 2'd2
    } cad_ev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_SET   = 3'd0,
        CFG_ALARM_CLEAR = 3'd1,
        CFG_SUSTAIN     = 3'd2,
        CFG_BUSY_UTIL   = 3'd3,
        CFG_BUSY_TEMP   = 3'd4,
        CFG_FAILS       = 3'd5,
        CFG_RELAX       = 3'd6,
        CFG_CAP         = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] alarm_set_temp;
        logic signed [TEMP_W-1:0] alarm_clear_temp;
        logic [SUST_W-1:0]        alarm_sustain_ms;
        logic [UTIL_W-1:0]        busy_util_level;
        logic signed [TEMP_W-1:0] busy_temp_level;
        logic [FAIL_W-1:0]        fails_to_offline;
        logic [CALM_W-1:0]        calm_polls_to_relax;
        logic [DELAY_W-1:0]       backoff_cap_ms;
    } cfg_t;

    typedef struct packed {
        logic                     link_up;
        logic                     poll_ok;
        logic [TIME_W-1:0]        time_ms;
        logic                     gpu_temp_valid;
        logic signed [TEMP_W-1:0] gpu_temp;
        logic                     cpu_temp_valid;
        logic signed [TEMP_W-1:0] cpu_temp;
        logic                     util_valid;
        logic [UTIL_W-1:0]        gpu_util;
        logic                     driver_known;
        logic                     driver_loaded;
    } item_t;

    typedef struct packed {
        logic [FAIL_W-1:0]        fail_count;
        logic [CALM_W-1:0]        calm_count;
        logic [DELAY_W-1:0]       retry_delay;
        logic [TIME_W-1:0]        hit_start_time;
        logic                     hit_timing;
        logic                     alarm_held;
        health_t                  cur_state;
        logic                     busy_mode;
        logic signed [TEMP_W-1:0] held_alarm_temp;
        logic                     held_alarm_gpu;
    } sup_state_t;

    typedef struct packed {
        health_t                  health_state;
        logic [DELAY_W-1:0]       poll_gap_ms;
        logic                     cadence_busy;
        logic signed [TEMP_W-1:0] alarm_temp;
        logic                     alarm_from_gpu;
        logic                     came_online;
        logic                     went_offline;
        cad_ev_t                  cadence_event;
    } result_t;

endpackage

// ----- hw/rtl/plts_step.sv -----
module plts_step (
    input  plts_pkg::cfg_t       cfg,
    input  plts_pkg::item_t      item,
    input  plts_pkg::sup_state_t st,
    output plts_pkg::sup_state_t st_next,
    output plts_pkg::result_t    res
);
    import plts_pkg::*;

    logic                     gpu_hit;
    logic                     cpu_hit;
    logic                     hit;
    logic signed [TEMP_W-1:0] hit_temp;
    logic signed [TEMP_W-1:0] gpu_eff;
    logic signed [TEMP_W-1:0] cpu_eff;
    logic [TIME_W-1:0]        start_time;
    logic [TIME_W-1:0]        elapsed;
    logic                     trig;
    logic [CALM_W-1:0]        calm_inc;
    logic [FAIL_W-1:0]        fail_inc;
    logic [DELAY_W:0]         doubled;
    logic [DELAY_W-1:0]       delay;

    assign gpu_hit  = item.gpu_temp_valid &&
                      ($signed(item.gpu_temp) >= $signed(cfg.alarm_set_temp));
    assign cpu_hit  = item.cpu_temp_valid &&
                      ($signed(item.cpu_temp) >= $signed(cfg.alarm_set_temp));
    assign hit      = gpu_hit || cpu_hit;
    // gpu reading takes priority as the alarm source
    assign hit_temp = gpu_hit ? item.gpu_temp : item.cpu_temp;
    // an absent reading counts as zero for the clear test
    assign gpu_eff  = item.gpu_temp_valid ? item.gpu_temp : '0;
    assign cpu_eff  = item.cpu_temp_valid ? item.cpu_temp : '0;

    assign start_time = st.hit_timing ? st.hit_start_time : item.time_ms;
    assign elapsed    = item.time_ms - start_time;
    assign calm_inc   = (st.calm_count == CALM_MAX) ? CALM_MAX : st.calm_count + 1'b1;
    assign fail_inc   = (st.fail_count == FAIL_MAX) ? FAIL_MAX : st.fail_count + 1'b1;
    assign doubled    = {st.retry_delay, 1'b0};

    always_comb begin
        st_next          = st;
        delay            = BUSY_DELAY_MS;
        trig             = 1'b0;
        res.came_online  = 1'b0;
        res.went_offline = 1'b0;
        res.cadence_event = CAD_NONE;

        if (!item.link_up) begin
            st_next.retry_delay = BUSY_DELAY_MS;
            delay = BUSY_DELAY_MS;
        end else if (item.poll_ok) begin
            res.came_online     = (st.cur_state == ST_OFFLINE);
            st_next.fail_count  = '0;
            st_next.retry_delay = BUSY_DELAY_MS;
            st_next.cur_state   = (item.driver_known && !item.driver_loaded) ?
                                  ST_NODRIVER : ST_NORMAL;

            if (hit) begin
                st_next.hit_timing     = 1'b1;
                st_next.hit_start_time = start_time;
                if (!st.alarm_held &&
                    (elapsed >= {{(TIME_W-SUST_W){1'b0}}, cfg.alarm_sustain_ms})) begin
                    st_next.alarm_held      = 1'b1;
                    st_next.held_alarm_temp = hit_temp;
                    st_next.held_alarm_gpu  = gpu_hit;
                end
            end else if (($signed(gpu_eff) < $signed(cfg.alarm_clear_temp)) &&
                         ($signed(cpu_eff) < $signed(cfg.alarm_clear_temp))) begin
                st_next.hit_timing = 1'b0;
                st_next.alarm_held = 1'b0;
            end
            if (st_next.alarm_held) begin
                st_next.cur_state = ST_ALARM;
            end

            trig = (item.util_valid && (item.gpu_util >= cfg.busy_util_level)) ||
                   (item.gpu_temp_valid &&
                    ($signed(item.gpu_temp) >= $signed(cfg.busy_temp_level))) ||
                   st_next.alarm_held;
            if (trig) begin
                st_next.calm_count = '0;
                if (!st.busy_mode) begin
                    st_next.busy_mode = 1'b1;
                    res.cadence_event = CAD_TO_BUSY;
                end
            end else if (st.busy_mode) begin
                if (calm_inc >= cfg.calm_polls_to_relax) begin
                    st_next.busy_mode  = 1'b0;
                    st_next.calm_count = '0;
                    res.cadence_event  = CAD_TO_CALM;
                end else begin
                    st_next.calm_count = calm_inc;
                end
            end
            delay = st_next.busy_mode ? BUSY_DELAY_MS : CALM_DELAY_MS;
        end else begin
            st_next.fail_count = fail_inc;
            if (fail_inc >= cfg.fails_to_offline) begin
                res.went_offline  = (st.cur_state != ST_OFFLINE);
                st_next.cur_state = ST_OFFLINE;
            end
            if (doubled > {1'b0, cfg.backoff_cap_ms}) begin
                st_next.retry_delay = cfg.backoff_cap_ms;
            end else begin
                st_next.retry_delay = doubled[DELAY_W-1:0];
            end
            delay = st_next.retry_delay;
        end

        res.health_state   = st_next.cur_state;
        res.poll_gap_ms    = delay;
        res.cadence_busy   = st_next.busy_mode;
        res.alarm_temp     = st_next.held_alarm_temp;
        res.alarm_from_gpu = st_next.held_alarm_gpu;
    end

endmodule

// ----- hw/rtl/poll_link_thermal_supervisor_unit.sv -----
// Poll-link thermal supervisor: one item per status poll outcome.
// Input channel s_*: valid/ready; each accepted item updates the failure
// streak, retry backoff, over-temperature alarm and busy/calm cadence.
// Result channel m_*: valid/ready; exactly one result per accepted item,
// carrying health state, next poll delay, cadence, the held alarm reading
// and the online/offline/cadence edge events.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle,
// to be used only while no item is in flight.
// An accepted item waits in the input register, and its result is taken into
// the result register once that register is empty or m_ready is high.
// Throughput: one item per cycle while m_ready stays high; the input and
// result registers each hold one item, and all state updates happen in the
// single step between them.
// A stalled receiver holds the result register; the input register then
// fills and s_ready drops until m_ready returns.
// Reset (aresetn low at a clock edge) empties both registers, restores
// register defaults and puts the supervisor offline, calm, alarm clear.
module poll_link_thermal_supervisor_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [plts_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [plts_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_link_up,
    input  logic                                   s_poll_ok,
    input  logic [plts_pkg::TIME_W-1:0]            s_time_ms,
    input  logic                                   s_gpu_temp_valid,
    input  logic signed [plts_pkg::TEMP_W-1:0]     s_gpu_temp,
    input  logic                                   s_cpu_temp_valid,
    input  logic signed [plts_pkg::TEMP_W-1:0]     s_cpu_temp,
    input  logic                                   s_util_valid,
    input  logic [plts_pkg::UTIL_W-1:0]            s_gpu_util,
    input  logic                                   s_driver_known,
    input  logic                                   s_driver_loaded,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_health_state,
    output logic [plts_pkg::DELAY_W-1:0]           m_poll_gap_ms,
    output logic                                   m_cadence_busy,
    output logic signed [plts_pkg::TEMP_W-1:0]     m_alarm_temp,
    output logic                                   m_alarm_from_gpu,
    output logic                                   m_came_online,
    output logic                                   m_went_offline,
    output logic [1:0]                             m_cadence_event
);
    import plts_pkg::*;

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       in_valid_reg;
    sup_state_t st_reg;
    sup_state_t st_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_set_temp      <= ALARM_SET_RST;
            cfg_reg.alarm_clear_temp    <= ALARM_CLEAR_RST;
            cfg_reg.alarm_sustain_ms    <= SUSTAIN_RST;
            cfg_reg.busy_util_level     <= BUSY_UTIL_RST;
            cfg_reg.busy_temp_level     <= BUSY_TEMP_RST;
            cfg_reg.fails_to_offline    <= FAILS_RST;
            cfg_reg.calm_polls_to_relax <= RELAX_RST;
            cfg_reg.backoff_cap_ms      <= CAP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALARM_SET:   cfg_reg.alarm_set_temp   <= cfg_wdata[TEMP_W-1:0];
                CFG_ALARM_CLEAR: cfg_reg.alarm_clear_temp <= cfg_wdata[TEMP_W-1:0];
                CFG_SUSTAIN:     cfg_reg.alarm_sustain_ms <= cfg_wdata[SUST_W-1:0];
                CFG_BUSY_UTIL:   cfg_reg.busy_util_level  <= cfg_wdata[UTIL_W-1:0];
                CFG_BUSY_TEMP:   cfg_reg.busy_temp_level  <= cfg_wdata[TEMP_W-1:0];
                CFG_FAILS:       cfg_reg.fails_to_offline <= cfg_wdata[FAIL_W-1:0];
                CFG_RELAX:       cfg_reg.calm_polls_to_relax <= cfg_wdata[CALM_W-1:0];
                CFG_CAP:         cfg_reg.backoff_cap_ms   <= cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.link_up        <= s_link_up;
            item_reg.poll_ok        <= s_poll_ok;
            item_reg.time_ms        <= s_time_ms;
            item_reg.gpu_temp_valid <= s_gpu_temp_valid;
            item_reg.gpu_temp       <= s_gpu_temp;
            item_reg.cpu_temp_valid <= s_cpu_temp_valid;
            item_reg.cpu_temp       <= s_cpu_temp;
            item_reg.util_valid     <= s_util_valid;
            item_reg.gpu_util       <= s_gpu_util;
            item_reg.driver_known   <= s_driver_known;
            item_reg.driver_loaded  <= s_driver_loaded;
        end
    end

    plts_step u_step (
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.fail_count      <= '0;
            st_reg.calm_count      <= '0;
            st_reg.retry_delay     <= BUSY_DELAY_MS;
            st_reg.hit_start_time  <= '0;
            st_reg.hit_timing      <= 1'b0;
            st_reg.alarm_held      <= 1'b0;
            st_reg.cur_state       <= ST_OFFLINE;
            st_reg.busy_mode       <= 1'b0;
            st_reg.held_alarm_temp <= '0;
            st_reg.held_alarm_gpu  <= 1'b0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_health_state   = res_reg.health_state;
    assign m_poll_gap_ms    = res_reg.poll_gap_ms;
    assign m_cadence_busy   = res_reg.cadence_busy;
    assign m_alarm_temp     = res_reg.alarm_temp;
    assign m_alarm_from_gpu = res_reg.alarm_from_gpu;
    assign m_came_online    = res_reg.came_online;
    assign m_went_offline   = res_reg.went_offline;
    assign m_cadence_event  = res_reg.cadence_event;

    // a latched alarm always has a running hit timer behind it
    a_latch_needs_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.alarm_held |-> st_reg.hit_timing)
        else $error("alarm latched without hit timer");

    a_events_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_came_online && m_went_offline))
        else $error("online and offline events in one item");

    a_offline_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_went_offline) |-> (m_health_state == ST_OFFLINE))
        else $error("offline event without offline state");

    a_busy_event_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cadence_event == CAD_TO_BUSY)) |-> m_cadence_busy)
        else $error("busy event while cadence calm");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("supervisor state changed without an item");

endmodule
